// File: hw/rtl/gref_pkg.sv
// shared types, constants and helpers for the grant reference free list
package gref_pkg;

  localparam int ENTRIES  = 256;
  localparam int RESERVED = 8;
  localparam int FIELD_W  = 9;
  localparam int IDX_W    = $clog2(ENTRIES);

  localparam logic [FIELD_W-1:0] END_MARK    = FIELD_W'(ENTRIES + 1);
  localparam logic [FIELD_W-1:0] ENTRIES_V   = FIELD_W'(ENTRIES);
  localparam logic [FIELD_W-1:0] RESET_HEAD  = FIELD_W'(RESERVED);
  localparam logic [FIELD_W-1:0] RESET_TOTAL = FIELD_W'(ENTRIES - RESERVED);

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_CHAIN   = 3'd2;
  localparam logic [2:0] OP_CLAIM   = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;

  localparam logic [1:0] RD_HEAD = 2'd0;
  localparam logic [1:0] RD_REF  = 2'd1;
  localparam logic [1:0] RD_PH   = 2'd2;
  localparam logic [1:0] RD_LINK = 2'd3;

  localparam logic [2:0] FIN_FAIL    = 3'd0;
  localparam logic [2:0] FIN_EMPTY   = 3'd1;
  localparam logic [2:0] FIN_ALLOC   = 3'd2;
  localparam logic [2:0] FIN_FREE    = 3'd3;
  localparam logic [2:0] FIN_CHAIN   = 3'd4;
  localparam logic [2:0] FIN_CLAIM   = 3'd5;
  localparam logic [2:0] FIN_RELEASE = 3'd6;

  typedef struct packed {
    logic [2:0]         op;
    logic [FIELD_W-1:0] count;
    logic [FIELD_W-1:0] ref_req;
    logic [FIELD_W-1:0] priv_head;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] got_ref;
    logic [FIELD_W-1:0] new_priv_head;
    logic [FIELD_W-1:0] free_left;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rd_src;
    logic       fin_en;
    logic [2:0] fin;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       alloc_ok;
    logic       ref_valid;
    logic       ref_is_end;
    logic       ph_valid;
    logic       link_end;
    logic       link_bad;
    logic       k_done;
    logic       n_max;
  } dp_sts_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [FIELD_W-1:0] wdata;
  } mem_req_t;

  function automatic logic [FIELD_W-1:0] init_link(input logic [IDX_W-1:0] idx);
    logic [FIELD_W-1:0] v;
    v = (idx == IDX_W'(ENTRIES - 1)) ? END_MARK : (FIELD_W'(idx) + FIELD_W'(1));
    return v;
  endfunction

endpackage

// File: hw/rtl/gref_link_mem.sv
// next-link table with per-entry written flags and registered read
module gref_link_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gref_pkg::mem_req_t        req,
  output logic [gref_pkg::FIELD_W-1:0] rd_data
);
  import gref_pkg::*;

  logic [FIELD_W-1:0] link_mem [ENTRIES];
  logic [ENTRIES-1:0] written_r;
  logic [FIELD_W-1:0] mem_q_r;
  logic [FIELD_W-1:0] dflt_r;
  logic               hit_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      link_mem[req.waddr] <= req.wdata;
    end
    if (req.rd_en) begin
      mem_q_r <= link_mem[req.rd_addr];
      dflt_r  <= init_link(req.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      hit_r     <= 1'b0;
    end else begin
      if (req.we) begin
        written_r[req.waddr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_r <= written_r[req.rd_addr];
      end
    end
  end

  assign rd_data = hit_r ? mem_q_r : dflt_r;

endmodule

// File: hw/rtl/gref_datapath.sv
// operand, walk and free list registers plus result register
module gref_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gref_pkg::in_item_t           in_item,
  input  gref_pkg::dp_cmd_t            cmd,
  input  logic [gref_pkg::FIELD_W-1:0] rd_data,
  output gref_pkg::dp_sts_t            sts,
  output gref_pkg::mem_req_t           mem_req,
  output gref_pkg::out_item_t          out_item
);
  import gref_pkg::*;

  in_item_t           in_r;
  out_item_t          out_r;
  out_item_t          out_nxt;
  logic [FIELD_W-1:0] free_head_r;
  logic [FIELD_W-1:0] free_head_nxt;
  logic [FIELD_W-1:0] free_total_r;
  logic [FIELD_W-1:0] free_total_nxt;
  logic [FIELD_W-1:0] tail_r;
  logic [FIELD_W-1:0] k_r;
  logic [FIELD_W-1:0] rd_src_val;
  logic [FIELD_W:0]   add_sum;
  logic [FIELD_W-1:0] add_sat;

  // status toward the controller
  always_comb begin
    sts.op         = in_r.op;
    sts.alloc_ok   = (in_r.count != '0) && (in_r.count <= free_total_r) &&
                     (free_head_r < ENTRIES_V);
    sts.ref_valid  = in_r.ref_req < ENTRIES_V;
    sts.ref_is_end = in_r.ref_req == END_MARK;
    sts.ph_valid   = in_r.priv_head < ENTRIES_V;
    sts.link_end   = rd_data == END_MARK;
    sts.link_bad   = rd_data >= ENTRIES_V;
    sts.k_done     = k_r == in_r.count;
    sts.n_max      = k_r >= ENTRIES_V;
  end

  always_comb begin
    case (cmd.rd_src)
      RD_HEAD: rd_src_val = free_head_r;
      RD_REF:  rd_src_val = in_r.ref_req;
      RD_PH:   rd_src_val = in_r.priv_head;
      RD_LINK: rd_src_val = rd_data;
      default: rd_src_val = rd_data;
    endcase
  end

  // saturating add of freed entries
  always_comb begin
    if (cmd.fin == FIN_FREE) begin
      add_sum = {1'b0, free_total_r} + (FIELD_W + 1)'(1);
    end else begin
      add_sum = {1'b0, free_total_r} + {1'b0, k_r};
    end
    add_sat = (add_sum > (FIELD_W + 1)'(ENTRIES)) ? ENTRIES_V : add_sum[FIELD_W-1:0];
  end

  always_comb begin
    mem_req.rd_en   = cmd.rd_en;
    mem_req.rd_addr = rd_src_val[IDX_W-1:0];
    mem_req.we      = 1'b0;
    mem_req.waddr   = tail_r[IDX_W-1:0];
    mem_req.wdata   = free_head_r;
    free_head_nxt   = free_head_r;
    free_total_nxt  = free_total_r;
    out_nxt.status        = 1'b1;
    out_nxt.got_ref       = END_MARK;
    out_nxt.new_priv_head = in_r.priv_head;
    case (cmd.fin)
      FIN_ALLOC: begin
        out_nxt.status  = 1'b0;
        out_nxt.got_ref = free_head_r;
        free_head_nxt   = rd_data;
        free_total_nxt  = free_total_r - in_r.count;
        mem_req.wdata   = END_MARK;
        mem_req.we      = cmd.fin_en;
      end
      FIN_FREE: begin
        out_nxt.status = 1'b0;
        free_head_nxt  = in_r.ref_req;
        free_total_nxt = add_sat;
        mem_req.waddr  = in_r.ref_req[IDX_W-1:0];
        mem_req.we     = cmd.fin_en;
      end
      FIN_CHAIN: begin
        out_nxt.status = 1'b0;
        free_head_nxt  = in_r.ref_req;
        free_total_nxt = add_sat;
        mem_req.we     = cmd.fin_en;
      end
      FIN_CLAIM: begin
        out_nxt.status        = 1'b0;
        out_nxt.got_ref       = in_r.priv_head;
        out_nxt.new_priv_head = rd_data;
      end
      FIN_RELEASE: begin
        out_nxt.status        = 1'b0;
        out_nxt.new_priv_head = in_r.ref_req;
        mem_req.waddr         = in_r.ref_req[IDX_W-1:0];
        mem_req.wdata         = in_r.priv_head;
        mem_req.we            = cmd.fin_en;
      end
      FIN_EMPTY: begin
        out_nxt.status = 1'b0;
      end
      default: begin
        out_nxt.status = 1'b1;
      end
    endcase
    out_nxt.free_left = free_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
    if (cmd.rd_en) begin
      tail_r <= rd_src_val;
      k_r    <= (cmd.rd_src == RD_LINK) ? (k_r + FIELD_W'(1)) : FIELD_W'(1);
    end
    if (cmd.fin_en) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r  <= RESET_HEAD;
      free_total_r <= RESET_TOTAL;
    end else if (cmd.fin_en) begin
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
    end
  end

  assign out_item = out_r;

endmodule

// File: hw/rtl/gref_ctrl.sv
// controller state machine: decode, link walks and result handoff
module gref_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gref_pkg::dp_sts_t   sts,
  output gref_pkg::dp_cmd_t   cmd
);
  import gref_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ALLOC  = 3'd2;
  localparam logic [2:0] S_CHAIN  = 3'd3;
  localparam logic [2:0] S_CLAIM  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] fin_r;
  logic [2:0] fin_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    cmd        = '0;
    cmd.fin    = fin_r;
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    in_ready   = state_r == S_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FIN;
        fin_nxt   = FIN_FAIL;
        case (sts.op)
          OP_ALLOC: begin
            if (sts.alloc_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_HEAD;
              state_nxt  = S_ALLOC;
            end
          end
          OP_FREE: begin
            if (sts.ref_valid) begin
              fin_nxt = FIN_FREE;
            end
          end
          OP_CHAIN: begin
            if (sts.ref_is_end) begin
              fin_nxt = FIN_EMPTY;
            end else if (sts.ref_valid) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_REF;
              state_nxt  = S_CHAIN;
            end
          end
          OP_CLAIM: begin
            if (sts.ph_valid) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_PH;
              state_nxt  = S_CLAIM;
            end
          end
          OP_RELEASE: begin
            if (sts.ref_valid) begin
              fin_nxt = FIN_RELEASE;
            end
          end
          default: begin
            fin_nxt = FIN_FAIL;
          end
        endcase
      end
      S_ALLOC: begin
        if (sts.k_done) begin
          fin_nxt   = FIN_ALLOC;
          state_nxt = S_FIN;
        end else if (sts.link_bad) begin
          fin_nxt   = FIN_FAIL;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_LINK;
        end
      end
      S_CHAIN: begin
        if (sts.link_end) begin
          fin_nxt   = FIN_CHAIN;
          state_nxt = S_FIN;
        end else if (sts.link_bad || sts.n_max) begin
          fin_nxt   = FIN_FAIL;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_LINK;
        end
      end
      S_CLAIM: begin
        fin_nxt   = FIN_CLAIM;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin_en = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= FIN_FAIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/grant_reference_free_list.sv
// top level of the grant reference free list allocator
//
// one request channel (in_valid/in_ready/in_item) and one result channel
// (out_valid/out_ready/out_item); every accepted request gives one result.
// requests: alloc run, free one, free chain, claim private, release private.
// a request is taken only while the controller is idle; the result sits in
// an output register, so the next request is taken while it waits.
// alloc walks the links of the count entries it takes, free chain walks
// the chain to its end, claim reads one link; free one, release and
// failures found at decode go straight to the final state; a walk stops
// on a bad link or a too long chain.
// the link walk reads the next-link table once per cycle through its
// single read port.
// a new request is taken in the cycle after the result is written.
// if out_ready stays low, the finished result holds, the next request is
// still processed, and its result waits in the final state until the
// output register is free.
// reset (rst_n low, synchronous) empties the output, puts the free list head
// at the first unreserved entry and marks every table entry as unwritten,
// so it reads back its initial link; no clearing pass is needed.
module grant_reference_free_list (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gref_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gref_pkg::out_item_t  out_item
);
  import gref_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  mem_req_t           mem_req;
  logic [FIELD_W-1:0] rd_data;

  gref_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gref_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .rd_data  (rd_data),
    .sts      (sts),
    .mem_req  (mem_req),
    .out_item (out_item)
  );

  gref_link_mem u_link_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
